[rtl/ttb_pkg.sv]
// shared types and constants for the tick timer bank
// no dependencies
package ttb_pkg;

   localparam int SLOT_W  = 3;
   localparam int VALUE_W = 32;
   localparam int TICKS_W = 32;
   localparam int MASK_W  = 8;

   localparam int DEF_NUM_TIMERS     = 8;
   localparam int DEF_NUM_COUNTERS   = 8;
   localparam int DEF_INTERVAL_WIDTH = 16;
   localparam int DEF_COUNT_WIDTH    = 32;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_START = 2'd1,
      ACT_LOAD  = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   // decoded command for one beat in the processing stage
   typedef struct packed {
      logic              tick;
      logic              start;
      logic [SLOT_W-1:0] slot;
   } timer_cmd_type;

endpackage

[rtl/ttb_timers.sv]
// periodic timers: remaining count and reload interval per timer, expiry mask
// depends on ttb_pkg
module ttb_timers #(
   parameter int NUM_TIMERS     = ttb_pkg::DEF_NUM_TIMERS,
   parameter int INTERVAL_WIDTH = ttb_pkg::DEF_INTERVAL_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ttb_pkg::timer_cmd_type    cmd,
   input  logic [INTERVAL_WIDTH-1:0] start_value,
   output logic [NUM_TIMERS-1:0]     expired
);
   import ttb_pkg::*;

   logic [INTERVAL_WIDTH-1:0] remaining_ff [NUM_TIMERS];
   logic [INTERVAL_WIDTH-1:0] remaining_in [NUM_TIMERS];
   logic [INTERVAL_WIDTH-1:0] reload_ff    [NUM_TIMERS];
   logic [INTERVAL_WIDTH-1:0] reload_in    [NUM_TIMERS];

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_timer
      logic hit;
      assign hit = cmd.start && (32'(cmd.slot) == i);

      always_comb begin
         remaining_in[i] = remaining_ff[i];
         reload_in[i]    = reload_ff[i];
         expired[i]      = 1'b0;
         if (hit) begin
            remaining_in[i] = start_value;
            reload_in[i]    = start_value;
         end else if (cmd.tick) begin
            // zero means disabled
            if (remaining_ff[i] == INTERVAL_WIDTH'(1)) begin
               remaining_in[i] = reload_ff[i];
               expired[i]      = 1'b1;
            end else if (remaining_ff[i] != '0) begin
               remaining_in[i] = remaining_ff[i] - INTERVAL_WIDTH'(1);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            remaining_ff[i] <= '0;
            reload_ff[i]    <= '0;
         end else begin
            remaining_ff[i] <= remaining_in[i];
            reload_ff[i]    <= reload_in[i];
         end
      end
   end

endmodule

[rtl/tick_timer_bank_core.sv]
// top level of the tick timer bank: input stage, down-counters, result register
// depends on ttb_pkg and ttb_timers
//
// Each request beat is one action: tick, start a timer, load a down-counter or
// read a down-counter, and each gives exactly one response beat. The block takes
// one beat per clock while the response side keeps up; a beat is held in the
// input register, is processed as it moves into the response register, and shows
// on rsp_* from that register. All timers and down-counters update in parallel in
// that one step, so throughput is one beat per cycle while the response side keeps
// up; a stalled response holds the input stage, which then stalls the request side.
module tick_timer_bank_core #(
   parameter int NUM_TIMERS     = ttb_pkg::DEF_NUM_TIMERS,
   parameter int NUM_COUNTERS   = ttb_pkg::DEF_NUM_COUNTERS,
   parameter int INTERVAL_WIDTH = ttb_pkg::DEF_INTERVAL_WIDTH,
   parameter int COUNT_WIDTH    = ttb_pkg::DEF_COUNT_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_action,
   input  logic [ttb_pkg::SLOT_W-1:0]   req_slot,
   input  logic [ttb_pkg::VALUE_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ttb_pkg::MASK_W-1:0]   rsp_expired_mask,
   output logic [ttb_pkg::TICKS_W-1:0]  rsp_now_ticks,
   output logic [ttb_pkg::VALUE_W-1:0]  rsp_counter_value,
   output logic                         rsp_counter_zero
);
   import ttb_pkg::*;

   localparam logic [63:0] IVL_MAX = {64{1'b1}} >> (64 - INTERVAL_WIDTH);
   localparam logic [63:0] CNT_MAX = {64{1'b1}} >> (64 - COUNT_WIDTH);

   // input stage
   logic               in_valid_ff;
   logic [1:0]         action_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [VALUE_W-1:0] value_ff;

   // response stage
   logic               out_valid_ff;
   logic [MASK_W-1:0]  mask_ff;
   logic [TICKS_W-1:0] now_ff;
   logic [VALUE_W-1:0] cnt_value_ff;
   logic               cnt_zero_ff;

   // state
   logic [TICKS_W-1:0]     ticks_ff;
   logic [TICKS_W-1:0]     ticks_in;
   logic [COUNT_WIDTH-1:0] count_ff [NUM_COUNTERS];
   logic [COUNT_WIDTH-1:0] count_in [NUM_COUNTERS];

   logic                      out_ready;
   logic                      process;
   logic                      req_take;
   timer_cmd_type             cmd;
   logic                      do_load;
   logic [63:0]               value64;
   logic [INTERVAL_WIDTH-1:0] ivl_sat;
   logic [COUNT_WIDTH-1:0]    cnt_sat;
   logic [NUM_TIMERS-1:0]     expired;
   logic [31:0]               expired32;
   logic [COUNT_WIDTH-1:0]    sel_count;
   logic [63:0]               sel_count64;

   assign out_ready = !out_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cmd     = '0;
      do_load = 1'b0;
      case (action_type'(action_ff))
         ACT_TICK:  cmd.tick  = process;
         ACT_START: cmd.start = process;
         ACT_LOAD:  do_load   = process;
         ACT_READ:  ;
         default:   ;
      endcase
      cmd.slot = slot_ff;
   end

   assign value64 = 64'(value_ff);
   assign ivl_sat = (value64 > IVL_MAX) ? IVL_MAX[INTERVAL_WIDTH-1:0]
                                        : value64[INTERVAL_WIDTH-1:0];
   assign cnt_sat = (value64 > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0]
                                        : value64[COUNT_WIDTH-1:0];

   ttb_timers #(
      .NUM_TIMERS     (NUM_TIMERS),
      .INTERVAL_WIDTH (INTERVAL_WIDTH)
   ) u_timers (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .start_value (ivl_sat),
      .expired     (expired)
   );

   assign ticks_in = cmd.tick ? ticks_ff + TICKS_W'(1) : ticks_ff;

   for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_counter
      always_comb begin
         count_in[i] = count_ff[i];
         if (do_load && (32'(slot_ff) == i)) begin
            count_in[i] = cnt_sat;
         end else if (cmd.tick && (count_ff[i] != '0)) begin
            count_in[i] = count_ff[i] - COUNT_WIDTH'(1);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            count_ff[i] <= '0;
         end else begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   // addressed counter after this beat, zero when the slot is out of range
   always_comb begin
      sel_count = '0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
         if (32'(slot_ff) == i) begin
            sel_count = count_in[i];
         end
      end
   end

   assign sel_count64 = 64'(sel_count);
   assign expired32   = 32'(expired);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ticks_ff     <= '0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (process) begin
            in_valid_ff <= 1'b0;
         end
         if (process) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         ticks_ff <= ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff <= req_action;
         slot_ff   <= req_slot;
         value_ff  <= req_value;
      end
      if (process) begin
         mask_ff      <= expired32[MASK_W-1:0];
         now_ff       <= ticks_in;
         cnt_value_ff <= sel_count64[VALUE_W-1:0];
         cnt_zero_ff  <= (sel_count == '0);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_expired_mask  = mask_ff;
   assign rsp_now_ticks     = now_ff;
   assign rsp_counter_value = cnt_value_ff;
   assign rsp_counter_zero  = cnt_zero_ff;

endmodule

[rtl/ttb_checker.sv]
// port-level checks for the tick timer bank, bound to the top level
// depends on ttb_pkg and tick_timer_bank_core
module ttb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [ttb_pkg::MASK_W-1:0]   rsp_expired_mask,
   input logic [ttb_pkg::TICKS_W-1:0]  rsp_now_ticks,
   input logic [ttb_pkg::VALUE_W-1:0]  rsp_counter_value,
   input logic                         rsp_counter_zero
);
   import ttb_pkg::*;

   logic [TICKS_W-1:0] last_ticks_ff;
   logic               rsp_beat;

   assign rsp_beat = rsp_valid && !rsp_stall;

   // tick count of the last delivered beat, zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ticks_ff <= '0;
      end else if (rsp_beat) begin
         last_ticks_ff <= rsp_now_ticks;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_now_ticks)
         && $stable(rsp_counter_value) && $stable(rsp_expired_mask))
      else $error("stalled response changed");

   a_ticks_step: assert property (@(posedge clock) disable iff (reset)
      rsp_beat |-> (rsp_now_ticks == last_ticks_ff)
         || (rsp_now_ticks == last_ticks_ff + TICKS_W'(1)))
      else $error("tick count moved by more than one between beats");

   a_expiry_on_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && (rsp_expired_mask != '0) |-> rsp_now_ticks == last_ticks_ff + TICKS_W'(1))
      else $error("expiry reported on a beat that was not a tick");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_counter_value != '0) |-> !rsp_counter_zero)
      else $error("counter zero flag set with a nonzero count");

endmodule

bind tick_timer_bank_core ttb_checker u_ttb_checker (.*);
